@@ hw/rtl/whb_pkg.sv @@
// Shared types, constants and helpers of the weighted histogram binner.
package whb_pkg;

  // Sizing
  localparam int MAX_BINS = 256;
  localparam int SUM_W    = 48;
  localparam int SLOT_W   = $clog2(MAX_BINS + 1);
  localparam int DEPTH    = MAX_BINS + 1;
  localparam int Q_W      = 32;
  localparam int DIFF_W   = Q_W + 1;
  localparam int IDX_W    = DIFF_W;
  localparam int ADDR_W   = 4;

  // Action codes
  localparam logic [1:0] ACT_BIN  = 2'd0;
  localparam logic [1:0] ACT_READ = 2'd1;
  localparam logic [1:0] ACT_RCLR = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_LOW   = 2'd0;
  localparam logic [1:0] REG_HIGH  = 2'd1;
  localparam logic [1:0] REG_SCALE = 2'd2;
  localparam logic [1:0] REG_NBINS = 2'd3;

  // Saturation limits of a slot sum
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef struct packed {
    logic signed [Q_W-1:0] low_end;
    logic signed [Q_W-1:0] high_end;
    logic [Q_W-1:0]        bin_scale;
    logic [SLOT_W-1:0]     num_bins;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic calc;
    logic mul;
    logic pick;
    logic rd;
    logic add;
    logic commit;
    logic clr_write;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic out_free;
  } sts_t;

  // Bins in use: zero counts as one, and the count is capped at MAX_BINS
  function automatic logic [SLOT_W-1:0] eff_bins(input logic [SLOT_W-1:0] n);
    logic [SLOT_W-1:0] r;
    if (n == '0) begin
      r = SLOT_W'(1);
    end else if (n > SLOT_W'(MAX_BINS)) begin
      r = SLOT_W'(MAX_BINS);
    end else begin
      r = n;
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/whb_regs.sv @@
// Configuration registers behind the APB-style port.
module whb_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [whb_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output whb_pkg::cfg_t              cfg
);
  import whb_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_end   <= '0;
      cfg.high_end  <= 32'sd16777216;
      cfg.bin_scale <= 32'd65536;
      cfg.num_bins  <= SLOT_W'(MAX_BINS);
    end else if (wr_en) begin
      case (reg_idx)
        REG_LOW:   cfg.low_end   <= pwdata;
        REG_HIGH:  cfg.high_end  <= pwdata;
        REG_SCALE: cfg.bin_scale <= pwdata;
        REG_NBINS: cfg.num_bins  <= pwdata[SLOT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_idx)
      REG_LOW:   prdata = cfg.low_end;
      REG_HIGH:  prdata = cfg.high_end;
      REG_SCALE: prdata = cfg.bin_scale;
      REG_NBINS: prdata = {{(32-SLOT_W){1'b0}}, cfg.num_bins};
      default:   prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/whb_ctrl.sv @@
// Sequencing state machine: clearing pass, then one item at a time.
module whb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  whb_pkg::sts_t sts,
  output whb_pkg::cmd_t cmd
);
  import whb_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_CALC   = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_PICK   = 3'd4;
  localparam logic [2:0] S_RD     = 3'd5;
  localparam logic [2:0] S_ADD    = 3'd6;
  localparam logic [2:0] S_COMMIT = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid & ~in_stall;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          state_next  = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_PICK;
      end
      S_PICK: begin
        cmd.pick   = 1'b1;
        state_next = S_RD;
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add    = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        // hold until the result register can take the item
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Checks
  a_clear_stalls: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> in_stall)
    else $error("item accepted during clearing pass");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_CALC))
    else $error("accepted item did not start processing");

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> sts.out_free)
    else $error("result committed over an untaken result");

  a_commit_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> (state == S_IDLE))
    else $error("controller did not return to idle after commit");

endmodule

@@ hw/rtl/whb_dp.sv @@
// Datapath: slot calculation, sum memory, saturating add, result register.
module whb_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  whb_pkg::cmd_t              cmd,
  output whb_pkg::sts_t              sts,
  input  whb_pkg::cfg_t              cfg,
  input  logic [1:0]                 action,
  input  logic signed [31:0]         sample_value,
  input  logic                       value_is_nan,
  input  logic signed [31:0]         sample_weight,
  input  logic [whb_pkg::SLOT_W-1:0] read_slot,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [whb_pkg::SLOT_W-1:0] slot,
  output logic                       dropped,
  output logic signed [47:0]         slot_sum,
  output logic                       saturated
);
  import whb_pkg::*;

  // Item registers
  logic [1:0]               act_r;
  logic signed [Q_W-1:0]    val_r;
  logic                     nan_r;
  logic signed [Q_W-1:0]    wgt_r;
  logic [SLOT_W-1:0]        rslot_r;

  // Stage registers
  logic                     in_range_r;
  logic [DIFF_W-1:0]        diff_r;
  logic [IDX_W-1:0]         idx_r;
  logic [SLOT_W-1:0]        slot_r;
  logic signed [SUM_W-1:0]  mem_q;
  logic signed [SUM_W-1:0]  new_sum_r;
  logic                     sat_r;

  // Sum memory and clearing counter
  logic signed [SUM_W-1:0]  mem [0:DEPTH-1];
  logic [SLOT_W-1:0]        clr_cnt;

  logic                     is_bin;
  logic                     bin_live;
  logic [SLOT_W-1:0]        nb;
  logic [SLOT_W-1:0]        bin_slot;
  logic [SLOT_W-1:0]        rd_slot;
  logic [DIFF_W+Q_W-1:0]    prod;
  logic signed [SUM_W:0]    sum_wide;
  logic                     mem_we;
  logic [SLOT_W-1:0]        mem_wa;
  logic signed [SUM_W-1:0]  mem_wd;

  assign is_bin   = (act_r == ACT_BIN);
  assign bin_live = is_bin & ~nan_r;
  assign nb       = eff_bins(cfg.num_bins);
  assign prod     = diff_r * {{(DIFF_W-Q_W){1'b0}}, cfg.bin_scale};

  // Bin slot clamps to the overflow slot; reads clamp the requested slot
  assign bin_slot = !in_range_r ? nb :
                    (idx_r > {{(IDX_W-SLOT_W){1'b0}}, nb}) ? nb : idx_r[SLOT_W-1:0];
  assign rd_slot  = (rslot_r > nb) ? nb : rslot_r;

  assign sum_wide = {mem_q[SUM_W-1], mem_q} +
                    {{(SUM_W+1-Q_W){wgt_r[Q_W-1]}}, wgt_r};

  assign sts.clr_last = (clr_cnt == SLOT_W'(MAX_BINS));
  assign sts.out_free = ~out_valid | ~out_stall;

  // Capture the item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r   <= action;
      val_r   <= sample_value;
      nan_r   <= value_is_nan;
      wgt_r   <= sample_weight;
      rslot_r <= read_slot;
    end
  end

  // Range check and offset, product, slot choice
  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      in_range_r <= (val_r >= cfg.low_end) && (val_r <= cfg.high_end);
      diff_r     <= {val_r[Q_W-1], val_r} - {cfg.low_end[Q_W-1], cfg.low_end};
    end
    if (cmd.mul) begin
      idx_r <= prod[DIFF_W+Q_W-1:Q_W];
    end
    if (cmd.pick) begin
      if (is_bin) begin
        slot_r <= nan_r ? '0 : bin_slot;
      end else begin
        slot_r <= rd_slot;
      end
    end
  end

  // Saturating add of the weight
  always_ff @(posedge clk) begin
    if (cmd.add) begin
      if (!sum_wide[SUM_W] && sum_wide[SUM_W-1]) begin
        new_sum_r <= SUM_MAX;
        sat_r     <= 1'b1;
      end else if (sum_wide[SUM_W] && !sum_wide[SUM_W-1]) begin
        new_sum_r <= SUM_MIN;
        sat_r     <= 1'b1;
      end else begin
        new_sum_r <= sum_wide[SUM_W-1:0];
        sat_r     <= 1'b0;
      end
    end
  end

  // Memory write port: clearing pass or commit of an update
  always_comb begin
    mem_we = 1'b0;
    mem_wa = slot_r;
    mem_wd = '0;
    if (cmd.clr_write) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt;
    end else if (cmd.commit) begin
      if (bin_live) begin
        mem_we = 1'b1;
        mem_wd = new_sum_r;
      end else if (act_r == ACT_RCLR) begin
        mem_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.rd) begin
      mem_q <= mem[slot_r];
    end
  end

  // Advance the clearing counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_write && !sts.clr_last) begin
      clr_cnt <= clr_cnt + SLOT_W'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      slot      <= slot_r;
      dropped   <= is_bin & nan_r;
      saturated <= bin_live & sat_r;
      if (is_bin) begin
        slot_sum <= nan_r ? '0 : new_sum_r;
      end else begin
        slot_sum <= mem_q;
      end
    end
  end

endmodule

@@ hw/rtl/weighted_histogram_binner.sv @@
// Weighted histogram binner: accepts one item, sequences it through range check,
// multiply by the bin reciprocal, slot choice, memory read, saturating add and
// commit into the result register. The next item is accepted no sooner than the
// cycle after commit, so a new item is not taken before the last one is through;
// the controller's sequence takes one item at a time around the read-modify-write
// of the 257-entry sum memory. A finished result waits in an output register
// while the next item is taken, and commit holds while that register is still
// full. After reset a clearing pass zeroes all 257 sums; items are stalled
// during it, while register writes are taken at any time.
module weighted_histogram_binner (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 action,
  input  logic signed [31:0]         sample_value,
  input  logic                       value_is_nan,
  input  logic signed [31:0]         sample_weight,
  input  logic [whb_pkg::SLOT_W-1:0] read_slot,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [whb_pkg::SLOT_W-1:0] slot,
  output logic                       dropped,
  output logic signed [47:0]         slot_sum,
  output logic                       saturated,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [whb_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import whb_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  whb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  whb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  whb_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg           (cfg),
    .action        (action),
    .sample_value  (sample_value),
    .value_is_nan  (value_is_nan),
    .sample_weight (sample_weight),
    .read_slot     (read_slot),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .slot          (slot),
    .dropped       (dropped),
    .slot_sum      (slot_sum),
    .saturated     (saturated)
  );

endmodule

@@ sim/tb_weighted_histogram_binner.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the weighted histogram binner: stimulus, slot-sum predictor, checker.
module tb_weighted_histogram_binner;
  import whb_pkg::*;

  typedef struct packed {
    logic [1:0]            action;
    logic signed [31:0]    value;
    logic                  nan;
    logic signed [31:0]    weight;
    logic [SLOT_W-1:0]     rslot;
  } bin_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]     slot;
    logic                  dropped;
    logic signed [SUM_W-1:0] sum;
    logic                  sat;
  } bin_result_t;

  // Action 3 has no function of its own and reads like a plain read
  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_LO = -64'sh0000_8000_0000_0000;
  localparam int HOLD_LEN   = 300;
  localparam int SEG_ITEMS  = 250;
  localparam int RAMP_ITEMS = 16;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic [1:0]              action;
  logic signed [31:0]      sample_value;
  logic                    value_is_nan;
  logic signed [31:0]      sample_weight;
  logic [SLOT_W-1:0]       read_slot;
  logic                    out_valid;
  logic                    out_stall;
  logic [SLOT_W-1:0]       slot;
  logic                    dropped;
  logic signed [47:0]      slot_sum;
  logic                    saturated;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [ADDR_W-1:0]       paddr;
  logic [31:0]             pwdata;
  logic [31:0]             prdata;
  logic                    pready;

  // Predictor copy of the registers and the slot sums
  logic signed [31:0]      cfg_low;
  logic signed [31:0]      cfg_high;
  logic [31:0]             cfg_scale;
  logic [SLOT_W-1:0]       cfg_nbins;
  logic signed [SUM_W-1:0] sums_model [DEPTH];

  bin_item_t   pending_items [$];
  bin_result_t results_due [$];

  logic item_taken = 1'b0;
  logic hold_on    = 1'b0;
  int   hold_count = 0;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   items_sent;
  int   results_seen;
  int   mismatches;
  int   sat_seen;
  int   drop_seen;
  int   settings_used;

  weighted_histogram_binner i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .sample_value(sample_value), .value_is_nan(value_is_nan),
    .sample_weight(sample_weight), .read_slot(read_slot),
    .out_valid(out_valid), .out_stall(out_stall),
    .slot(slot), .dropped(dropped), .slot_sum(slot_sum), .saturated(saturated),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bail out if the run hangs
  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 100) begin
      $display("%0t ns mismatch: %s", $time, what);
    end
  endtask

  // Regular bins in use: zero means one, anything past the memory means all of it
  function automatic logic [SLOT_W-1:0] bins_in_use();
    logic [SLOT_W-1:0] n;
    n = cfg_nbins;
    if (n == '0) begin
      n = SLOT_W'(1);
    end
    if (n > SLOT_W'(MAX_BINS)) begin
      n = SLOT_W'(MAX_BINS);
    end
    return n;
  endfunction

  // Compute the result of one item and update the predicted sums
  function automatic bin_result_t predict_item(input bin_item_t it);
    bin_result_t       r;
    logic [SLOT_W-1:0] nb;
    longint            v;
    longint            lo;
    longint            hi;
    longint            sum;
    logic [63:0]       prod;
    logic [31:0]       idx;
    r = '0;
    nb = bins_in_use();
    if (it.action == ACT_BIN) begin
      if (it.nan) begin
        r.dropped = 1'b1;
      end else begin
        v = $signed(it.value);
        lo = cfg_low;
        hi = cfg_high;
        if (v >= lo && v <= hi) begin
          prod = 64'(v - lo) * {32'b0, cfg_scale};
          idx = prod[63:32];
          r.slot = (idx > 32'(nb)) ? nb : idx[SLOT_W-1:0];
        end else begin
          r.slot = nb;
        end
        sum = longint'(sums_model[r.slot]) + longint'($signed(it.weight));
        if (sum > SUM_HI) begin
          sum = SUM_HI;
          r.sat = 1'b1;
        end else if (sum < SUM_LO) begin
          sum = SUM_LO;
          r.sat = 1'b1;
        end
        sums_model[r.slot] = SUM_W'(sum);
        r.sum = SUM_W'(sum);
      end
    end else begin
      r.slot = (it.rslot > nb) ? nb : it.rslot;
      r.sum = sums_model[r.slot];
      if (it.action == ACT_RCLR) begin
        sums_model[r.slot] = '0;
      end
    end
    return r;
  endfunction

  // Offer items from the pending queue; hold the payload until it is taken
  always @(negedge clk) begin : send_items
    bin_item_t nxt;
    if (!rst && (!in_valid || item_taken)) begin
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        nxt = pending_items.pop_front();
        in_valid      <= 1'b1;
        action        <= nxt.action;
        sample_value  <= nxt.value;
        value_is_nan  <= nxt.nan;
        sample_weight <= nxt.weight;
        read_slot     <= nxt.rslot;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the result side at random, or for one long stretch on request
  always @(negedge clk) begin
    if (hold_on && hold_count < HOLD_LEN) begin
      out_stall  <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // Check taken results, then predict the item taken at this edge
  always @(posedge clk) begin : watch_channels
    bin_item_t   got;
    bin_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("result for slot %0d with no item outstanding", slot));
      end else begin
        want = results_due.pop_front();
        results_seen++;
        if (want.sat) sat_seen++;
        if (want.dropped) drop_seen++;
        if (slot !== want.slot) begin
          report_mismatch($sformatf("slot got %0d want %0d", slot, want.slot));
        end
        if (dropped !== want.dropped) begin
          report_mismatch($sformatf("dropped got %b want %b (slot %0d)",
                                    dropped, want.dropped, want.slot));
        end
        if (slot_sum !== want.sum) begin
          report_mismatch($sformatf("slot_sum got %h want %h (slot %0d)",
                                    slot_sum, want.sum, want.slot));
        end
        if (saturated !== want.sat) begin
          report_mismatch($sformatf("saturated got %b want %b (slot %0d)",
                                    saturated, want.sat, want.slot));
        end
      end
    end
    item_taken <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      got.action = action;
      got.value  = sample_value;
      got.nan    = value_is_nan;
      got.weight = sample_weight;
      got.rslot  = read_slot;
      results_due.insert(results_due.size(), predict_item(got));
    end
  end

  // Write one register: setup cycle, then access cycle until pready
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      REG_LOW:   cfg_low = data;
      REG_HIGH:  cfg_high = data;
      REG_SCALE: cfg_scale = data;
      REG_NBINS: cfg_nbins = data[SLOT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Load one full register setting
  task automatic apply_setting(input int seg);
    logic [31:0]       lo;
    logic [31:0]       hi;
    logic [31:0]       sc;
    logic [31:0]       t;
    logic [SLOT_W-1:0] nb;
    longint            span;
    longint            q;
    case (seg)
      0: begin
        lo = 32'hFFF0_0000; hi = 32'h0010_0000; sc = 32'h0004_0000; nb = 9'd128;
      end
      1: begin
        // random range, scale chosen so that the bins roughly cover it
        lo = $urandom();
        hi = $urandom();
        if ($signed(lo) > $signed(hi)) begin
          t = lo; lo = hi; hi = t;
        end
        nb = 9'($urandom_range(1, 256));
        span = longint'($signed(hi)) - longint'($signed(lo)) + 1;
        q = (longint'(nb) << 32) / span;
        sc = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(q);
      end
      2: begin
        lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; sc = 32'hFFFF_FFFF; nb = 9'd0;
      end
      3: begin
        // empty range: everything lands in the overflow slot
        lo = 32'h0005_0000; hi = 32'h0004_0000; sc = 32'h0001_0000; nb = 9'd17;
      end
      4: begin
        lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; sc = 32'h0000_0000; nb = 9'd511;
      end
      6: begin
        lo = 32'h0000_0000; hi = 32'h7FFF_FFFF; sc = 32'h0001_0000; nb = 9'd1;
      end
      default: begin
        lo = 32'hFFFF_FF00; hi = 32'h0000_0100; sc = 32'h7FFF_FFFF; nb = 9'd256;
      end
    endcase
    write_reg(REG_LOW, lo);
    write_reg(REG_HIGH, hi);
    write_reg(REG_SCALE, sc);
    write_reg(REG_NBINS, 32'(nb));
    settings_used++;
  endtask

  task automatic queue_item(input logic [1:0] act, input logic [31:0] v, input logic nan,
                            input logic [31:0] w, input logic [SLOT_W-1:0] rs);
    bin_item_t it;
    it.action = act;
    it.value  = v;
    it.nan    = nan;
    it.weight = w;
    it.rslot  = rs;
    pending_items.insert(pending_items.size(), it);
    items_sent++;
  endtask

  // Random item, biased toward the configured range and its edges
  function automatic bin_item_t random_item();
    bin_item_t it;
    longint    lo;
    longint    hi;
    longint    off;
    int        pick;
    lo = cfg_low;
    hi = cfg_high;
    it.value  = $urandom();
    it.weight = $urandom();
    it.rslot  = SLOT_W'($urandom_range(0, 511));
    it.nan    = ($urandom_range(0, 19) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 70) it.action = ACT_BIN;
    else if (pick < 80) it.action = ACT_READ;
    else if (pick < 92) it.action = ACT_RCLR;
    else it.action = ACT_SPARE;
    pick = $urandom_range(0, 9);
    if (pick < 6 && lo <= hi) begin
      off = {32'b0, $urandom()} % (hi - lo + 1);
      it.value = 32'(lo + off);
    end else if (pick < 8) begin
      case ($urandom_range(0, 3))
        0: it.value = cfg_low;
        1: it.value = cfg_high;
        2: it.value = cfg_low - 32'd1;
        default: it.value = cfg_high + 32'd1;
      endcase
    end
    case ($urandom_range(0, 3))
      0: it.weight = 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
      1: it.weight = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: ;
    endcase
    // aim some reads at the overflow slot and just past it
    if ($urandom_range(0, 3) == 0) begin
      it.rslot = bins_in_use() + SLOT_W'($urandom_range(0, 1));
    end
    return it;
  endfunction

  // Wait until every queued item has come back as a checked result
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || results_seen != items_sent);
  endtask

  initial begin : run
    rst           = 1'b1;
    in_valid      = 1'b0;
    action        = ACT_BIN;
    sample_value  = '0;
    value_is_nan  = 1'b0;
    sample_weight = '0;
    read_slot     = '0;
    out_stall     = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    tx_idle_pct   = 6;
    rx_idle_pct   = 85;
    items_sent    = 0;
    results_seen  = 0;
    mismatches    = 0;
    sat_seen      = 0;
    drop_seen     = 0;
    settings_used = 1;
    cfg_low       = 32'h0000_0000;
    cfg_high      = 32'h0100_0000;
    cfg_scale     = 32'h0001_0000;
    cfg_nbins     = 9'd256;
    foreach (sums_model[i]) sums_model[i] = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed items under the reset setting
    queue_item(ACT_BIN, 32'h0000_0000, 1'b0, 32'h0001_0000, 9'd0);    // lower edge
    queue_item(ACT_BIN, 32'h0000_8000, 1'b0, 32'h7FFF_FFFF, 9'h1FF);  // same bin again
    queue_item(ACT_BIN, 32'h00FF_FFFF, 1'b0, 32'h8000_0000, 9'd0);    // top regular bin
    queue_item(ACT_BIN, 32'h0100_0000, 1'b0, 32'h0000_0001, 9'd0);    // upper edge
    queue_item(ACT_BIN, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 9'd0);    // just below range
    queue_item(ACT_BIN, 32'h7FFF_FFFF, 1'b0, 32'h7FFF_FFFF, 9'd0);
    queue_item(ACT_BIN, 32'h8000_0000, 1'b0, 32'h8000_0000, 9'd0);
    queue_item(ACT_BIN, 32'h1234_5678, 1'b1, 32'h7FFF_FFFF, 9'h1FF);  // not a number
    queue_item(ACT_BIN, 32'h0000_0000, 1'b1, 32'h8000_0000, 9'd0);
    queue_item(ACT_READ, 32'h0, 1'b0, 32'h0, 9'd0);
    queue_item(ACT_READ, 32'h0, 1'b0, 32'h0, 9'd256);
    queue_item(ACT_READ, 32'h0, 1'b0, 32'h0, 9'd511);                 // past the overflow slot
    queue_item(ACT_RCLR, 32'h0, 1'b0, 32'h0, 9'd255);
    queue_item(ACT_READ, 32'h0, 1'b0, 32'h0, 9'd255);
    queue_item(ACT_SPARE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 9'd0);
    queue_item(ACT_SPARE, 32'h0, 1'b0, 32'h0, 9'd300);
    queue_item(ACT_RCLR, 32'h0, 1'b0, 32'h0, 9'd300);
    queue_item(ACT_RCLR, 32'h0, 1'b0, 32'h0, 9'd0);
    queue_item(ACT_READ, 32'h0, 1'b0, 32'h0, 9'd0);
    wait_drained();

    // Random items over several settings and idling patterns
    for (int seg = 0; seg < 6; seg++) begin
      tx_idle_pct = (seg < 2) ? 6 : (seg < 4) ? 85 : 0;
      rx_idle_pct = (seg < 2) ? 85 : (seg < 4) ? 6 : 0;
      apply_setting(seg);
      if (seg == 4) hold_on = 1'b1;
      for (int k = 0; k < SEG_ITEMS; k++) begin
        pending_items.insert(pending_items.size(), random_item());
        items_sent++;
      end
      wait_drained();
    end

    // Pile extreme positive weights onto the first slot and negative ones onto the overflow slot
    apply_setting(6);
    queue_item(ACT_RCLR, 32'h0, 1'b0, 32'h0, 9'd0);
    queue_item(ACT_RCLR, 32'h0, 1'b0, 32'h0, 9'd1);
    for (int k = 0; k < RAMP_ITEMS; k++) begin
      queue_item(ACT_BIN, 32'h0000_0000, 1'b0, 32'h7FFF_FFFF, SLOT_W'(k));
    end
    for (int k = 0; k < RAMP_ITEMS; k++) begin
      queue_item(ACT_BIN, 32'hFFFF_FFFF, 1'b0, 32'h8000_0000, SLOT_W'(k));
    end
    queue_item(ACT_RCLR, 32'h0, 1'b0, 32'h0, 9'd0);
    queue_item(ACT_RCLR, 32'h0, 1'b0, 32'h0, 9'd1);
    wait_drained();

    // Let any stray result surface
    repeat (16) @(posedge clk);
    $display("%0d items over %0d register settings, %0d results compared, %0d mismatches",
             items_sent, settings_used, results_seen, mismatches);
    $display("%0d saturated sums, %0d dropped items, output held off for %0d cycles",
             sat_seen, drop_seen, hold_count);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ weighted_histogram_binner.f @@
hw/rtl/whb_pkg.sv
hw/rtl/whb_regs.sv
hw/rtl/whb_ctrl.sv
hw/rtl/whb_dp.sv
hw/rtl/weighted_histogram_binner.sv
sim/tb_weighted_histogram_binner.sv
